// ===== sv/c2u_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c2u_pkg
// Shared types and the code page table for the Windows-1251 to UTF-8 block.
// ----------------------------------------------------------------------------
package c2u_pkg;

    // Width of one byte on either stream.
    localparam int unsigned ByteW = 8;

    // Base code point of the Cyrillic block at 0xC0..0xFF.
    localparam logic [15:0] CyrBase = 16'h0410;

    // One encoded character: up to three UTF-8 bytes and how many are used.
    typedef struct packed {
        logic [2:0][ByteW-1:0] bytes;   // bytes[0] goes out first
        logic [1:0]            len;     // 1, 2 or 3
    } t_run;

    // Code points for bytes 0x80..0xBF, indexed by the low six bits.
    function automatic logic [15:0] high_cp(input logic [5:0] idx);
        logic [15:0] cp;
        unique case (idx)
            6'd0:  cp = 16'h0402;  6'd1:  cp = 16'h0403;
            6'd2:  cp = 16'h201a;  6'd3:  cp = 16'h0453;
            6'd4:  cp = 16'h201e;  6'd5:  cp = 16'h2026;
            6'd6:  cp = 16'h2020;  6'd7:  cp = 16'h2021;
            6'd8:  cp = 16'h20ac;  6'd9:  cp = 16'h2030;
            6'd10: cp = 16'h0409;  6'd11: cp = 16'h2039;
            6'd12: cp = 16'h040a;  6'd13: cp = 16'h040c;
            6'd14: cp = 16'h040b;  6'd15: cp = 16'h040f;
            6'd16: cp = 16'h0452;  6'd17: cp = 16'h2018;
            6'd18: cp = 16'h2019;  6'd19: cp = 16'h201c;
            6'd20: cp = 16'h201d;  6'd21: cp = 16'h2022;
            6'd22: cp = 16'h2013;  6'd23: cp = 16'h2014;
            6'd24: cp = 16'hfffd;  6'd25: cp = 16'h2122;
            6'd26: cp = 16'h0459;  6'd27: cp = 16'h203a;
            6'd28: cp = 16'h045a;  6'd29: cp = 16'h045c;
            6'd30: cp = 16'h045b;  6'd31: cp = 16'h045f;
            6'd32: cp = 16'h00a0;  6'd33: cp = 16'h040e;
            6'd34: cp = 16'h045e;  6'd35: cp = 16'h0408;
            6'd36: cp = 16'h00a4;  6'd37: cp = 16'h0490;
            6'd38: cp = 16'h00a6;  6'd39: cp = 16'h00a7;
            6'd40: cp = 16'h0401;  6'd41: cp = 16'h00a9;
            6'd42: cp = 16'h0404;  6'd43: cp = 16'h00ab;
            6'd44: cp = 16'h00ac;  6'd45: cp = 16'h00ad;
            6'd46: cp = 16'h00ae;  6'd47: cp = 16'h0407;
            6'd48: cp = 16'h00b0;  6'd49: cp = 16'h00b1;
            6'd50: cp = 16'h0406;  6'd51: cp = 16'h0456;
            6'd52: cp = 16'h0491;  6'd53: cp = 16'h00b5;
            6'd54: cp = 16'h00b6;  6'd55: cp = 16'h00b7;
            6'd56: cp = 16'h0451;  6'd57: cp = 16'h2116;
            6'd58: cp = 16'h0454;  6'd59: cp = 16'h00bb;
            6'd60: cp = 16'h0458;  6'd61: cp = 16'h0405;
            6'd62: cp = 16'h0455;  6'd63: cp = 16'h0457;
        endcase
        return cp;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cp1251_to_utf8_transcoder.sv =====
`default_nettype none
// Path: an input byte is encoded into the run register at acceptance, and
// its first UTF-8 byte then moves on to the output register.
// Throughput: one output byte per cycle while m_axis_tready is not held low;
// an item goes out as 1, 2 or 3 bytes (its UTF-8 run) on the one-byte channel.
// Reset (synchronous, active low) empties the run and output registers.
// ----------------------------------------------------------------------------
// cp1251_to_utf8_transcoder
// Streams Windows-1251 bytes in and their UTF-8 encodings out, byte by byte.
// ----------------------------------------------------------------------------
module cp1251_to_utf8_transcoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // last_of_run
);
    import c2u_pkg::*;

    t_run       enc_run;
    t_run       r_run;
    logic       r_run_valid;
    logic [1:0] r_idx;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_valid;

    logic       out_free;
    logic       run_pop;
    logic       run_last;
    logic       in_xfer;
    logic       n_run_valid;
    logic [1:0] n_idx;

    c2u_encode u_encode (
        .i_byte (s_axis_tdata),
        .o_run  (enc_run)
    );

    // Handshake and flow control between run and output registers.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign run_pop       = r_run_valid && out_free;
    assign run_last      = (r_idx == (r_run.len - 2'd1));
    assign s_axis_tready = !r_run_valid || (run_pop && run_last);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Next state of the run register.
    always_comb begin
        n_run_valid = r_run_valid;
        n_idx       = r_idx;
        if (run_pop) begin
            if (run_last) begin
                n_run_valid = 1'b0;
                n_idx       = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (in_xfer) begin
            n_run_valid = 1'b1;
            n_idx       = 2'd0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_run_valid <= n_run_valid;
            r_idx       <= n_idx;
            if (out_free) begin
                r_out_valid <= r_run_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_run <= enc_run;
        end
        if (run_pop) begin
            r_out_byte <= r_run.bytes[r_idx];
            r_out_last <= run_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // The byte index never runs past the length of the held run.
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_idx < r_run.len))
        else $error("run index beyond run length");

    // An accepted byte always lands in the run register.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_run_valid && r_idx == 2'd0))
        else $error("accepted byte did not load the run register");

    // A held run always has between one and three bytes.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_run.len != 2'd0))
        else $error("empty run held");

    // A popped byte shows up as valid output on the next cycle.
    a_pop_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_pop |=> r_out_valid)
        else $error("popped byte missing on output");
`endif

endmodule
`default_nettype wire

// ===== sv/c2u_encode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c2u_encode
// Maps one Windows-1251 byte to its code point and builds the UTF-8 run.
// ----------------------------------------------------------------------------
module c2u_encode (
    input  wire logic [7:0]   i_byte,
    output c2u_pkg::t_run     o_run
);
    import c2u_pkg::*;

    logic [15:0] cp;

    // Code point lookup: Cyrillic letters, the table, or plain ASCII.
    always_comb begin
        priority if (i_byte[7:6] == 2'b11) begin
            cp = CyrBase + {10'd0, i_byte[5:0]};
        end else if (i_byte[7]) begin
            cp = high_cp(i_byte[5:0]);
        end else begin
            cp = {8'd0, i_byte};
        end
    end

    // UTF-8 encoding in one, two or three bytes.
    always_comb begin
        o_run.bytes = '0;
        priority if (cp[15:7] == '0) begin
            o_run.len      = 2'd1;
            o_run.bytes[0] = cp[7:0];
        end else if (cp[15:11] == '0) begin
            o_run.len      = 2'd2;
            o_run.bytes[0] = {3'b110, cp[10:6]};
            o_run.bytes[1] = {2'b10, cp[5:0]};
        end else begin
            o_run.len      = 2'd3;
            o_run.bytes[0] = {4'b1110, cp[15:12]};
            o_run.bytes[1] = {2'b10, cp[11:6]};
            o_run.bytes[2] = {2'b10, cp[5:0]};
        end
    end

endmodule
`default_nettype wire
